@@ sv/tte_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the timer table expiry engine.
// No dependencies; every other file but tte_ram imports this package.
package tte_pkg;

    // Table size and derived widths
    localparam int NUM_SLOTS   = 32;
    localparam int SLOT_AW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_CW     = $clog2(NUM_SLOTS + 1);

    // Field widths
    localparam int ACT_W       = 2;
    localparam int SLOT_W      = 5;
    localparam int DELAY_W     = 32;
    localparam int KIND_W      = 4;
    localparam int COUNT_W     = 6;
    localparam int DEADLINE_W  = 32;
    localparam int TIME_W      = 48;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 48;
    localparam int ENTRY_W     = TIME_W + KIND_W;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_SCHEDULE   = 2'd0,
        ACT_CANCEL     = 2'd1,
        ACT_TICK       = 2'd2,
        ACT_CANCEL_ALL = 2'd3
    } act_t;

    // Slave-side tdata layout, lowest field last
    typedef struct packed {
        logic [6:0]         pad;
        logic [KIND_W-1:0]  timer_type;
        logic [DELAY_W-1:0] wait_ms;
        logic [SLOT_W-1:0]  slot;
    } s_data_t;

    // Master-side tdata layout, lowest field last
    typedef struct packed {
        logic                  none_pending;
        logic [DEADLINE_W-1:0] next_deadline_ms;
        logic [COUNT_W-1:0]    expired_count;
        logic [KIND_W-1:0]     expired_type;
        logic [SLOT_W-1:0]     expired_slot;
    } m_data_t;

    // Classified command handed from front to back
    typedef struct packed {
        act_t               op;
        logic               slot_ok;
        logic [SLOT_W-1:0]  slot;
        logic [DELAY_W-1:0] wait_ms;
        logic [KIND_W-1:0]  kind;
    } cmd_t;

    // One slot table entry
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] expiry;
    } entry_t;

endpackage

@@ sv/tte_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tte_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/tte_front.sv @@
`timescale 1ns / 1ps
// Input stage: accepts stream transactions, decodes the action and checks the slot range.
// Depends on tte_pkg.
module tte_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  tte_pkg::s_data_t           s_tdata,
    input  logic [tte_pkg::ACT_W-1:0]  s_tuser,
    output logic                       cmd_valid,
    input  logic                       cmd_ready,
    output tte_pkg::cmd_t              cmd
);
    import tte_pkg::*;

    logic stage_valid_reg;
    logic stage_valid_next;
    cmd_t stage_reg;
    cmd_t stage_next;
    cmd_t decoded;

    // Classify the incoming transaction
    always_comb
    begin
        decoded.op       = act_t'(s_tuser);
        decoded.slot_ok  = ({1'b0, s_tdata.slot} < (SLOT_W + 1)'(NUM_SLOTS));
        decoded.slot     = s_tdata.slot;
        decoded.wait_ms  = s_tdata.wait_ms;
        decoded.kind     = s_tdata.timer_type;
    end

    assign s_tready  = !stage_valid_reg || cmd_ready;
    assign cmd_valid = stage_valid_reg;
    assign cmd       = stage_reg;

    // Staging register ahead of the queue
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (s_tvalid && s_tready)
        begin
            stage_valid_next = 1'b1;
            stage_next       = decoded;
        end
        else if (cmd_ready)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

endmodule

@@ sv/tte_queue.sv @@
`timescale 1ns / 1ps
// Short command queue decoupling the front stage from the execution engine.
// Depends on tte_pkg.
module tte_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  tte_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tte_pkg::cmd_t pop_cmd
);
    import tte_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW-1:0] rd_ptr_next;
    logic [QCW-1:0] fill_reg;
    logic [QCW-1:0] fill_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (fill_reg != QCW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ sv/tte_back.sv @@
`timescale 1ns / 1ps
// Execution engine: applies a command, scans the slot table, emits expiry and status results.
// Depends on tte_pkg and tte_ram.
module tte_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  tte_pkg::cmd_t                 cmd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output tte_pkg::m_data_t              m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);
    import tte_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_STATUS
    } state_t;

    state_t               state_reg,    state_next;
    logic [TIME_W-1:0]    now_reg,      now_next;
    logic [NUM_SLOTS-1:0] armed_reg,    armed_next;
    act_t                 op_reg,       op_next;
    logic [SLOT_CW-1:0]   rd_cnt_reg,   rd_cnt_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [SLOT_AW-1:0]   chk_idx_reg,  chk_idx_next;
    logic [SLOT_CW-1:0]   count_reg,    count_next;
    logic                 found_reg,    found_next;
    logic [TIME_W-1:0]    earliest_reg, earliest_next;
    logic                 out_valid_reg, out_valid_next;
    m_data_t              out_data_reg, out_data_next;
    logic                 out_exp_reg,  out_exp_next;
    logic                 out_last_reg, out_last_next;

    logic                 ram_wr_en;
    entry_t               ram_wr_data;
    logic                 ram_rd_en;
    entry_t               ram_rd_data;

    logic                 out_free;
    logic                 hit;
    logic                 due;
    logic                 emit;
    logic [TIME_W:0]      diff;
    logic                 ahead;
    logic [DEADLINE_W-1:0] deadline;

    // Slot table: expiry time and kind per slot
    tte_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (SLOT_AW'(cmd.slot)),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_cnt_reg[SLOT_AW-1:0]),
        .rd_data (ram_rd_data)
    );

    assign ram_wr_data.kind   = cmd.kind;
    assign ram_wr_data.expiry = now_reg + TIME_W'(cmd.wait_ms);

    assign cmd_ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || m_tready;

    // Scan compare on the entry returned by the last read issued
    assign hit  = chk_valid_reg && armed_reg[chk_idx_reg];
    assign due  = (ram_rd_data.expiry <= now_reg);
    assign emit = hit && due && (op_reg == ACT_TICK);

    // Time to earliest deadline, zero if due, saturated to the field width
    assign diff     = {1'b0, earliest_reg} - {1'b0, now_reg};
    assign ahead    = found_reg && !diff[TIME_W] && (diff[TIME_W-1:0] != '0);
    assign deadline = !ahead ? '0 :
                      (diff[TIME_W-1:DEADLINE_W] != '0) ? '1 : diff[DEADLINE_W-1:0];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_exp_reg;
    assign m_tlast  = out_last_reg;

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        armed_next     = armed_reg;
        op_next        = op_reg;
        rd_cnt_next    = rd_cnt_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        earliest_next  = earliest_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_exp_next   = out_exp_reg;
        out_last_next  = out_last_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        ACT_SCHEDULE:
                        begin
                            if (cmd.slot_ok)
                            begin
                                ram_wr_en                    = 1'b1;
                                armed_next[SLOT_AW'(cmd.slot)] = 1'b1;
                            end
                        end
                        ACT_CANCEL:
                        begin
                            if (cmd.slot_ok)
                            begin
                                armed_next[SLOT_AW'(cmd.slot)] = 1'b0;
                            end
                        end
                        ACT_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                        end
                        ACT_CANCEL_ALL:
                        begin
                            armed_next = '0;
                        end
                        default:
                        begin
                            now_next = now_reg;
                        end
                    endcase
                    op_next        = cmd.op;
                    rd_cnt_next    = '0;
                    chk_valid_next = 1'b0;
                    count_next     = '0;
                    found_next     = 1'b0;
                    state_next     = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (!chk_valid_reg && (rd_cnt_reg == SLOT_CW'(NUM_SLOTS)))
                begin
                    state_next = ST_STATUS;
                end
                else if (!emit || out_free)
                begin
                    // Issue the next read while evaluating the current entry
                    if (rd_cnt_reg < SLOT_CW'(NUM_SLOTS))
                    begin
                        ram_rd_en      = 1'b1;
                        chk_valid_next = 1'b1;
                        chk_idx_next   = rd_cnt_reg[SLOT_AW-1:0];
                        rd_cnt_next    = rd_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        chk_valid_next = 1'b0;
                    end

                    if (emit)
                    begin
                        armed_next[chk_idx_reg]        = 1'b0;
                        count_next                     = count_reg + 1'b1;
                        out_valid_next                 = 1'b1;
                        out_exp_next                   = 1'b1;
                        out_last_next                  = 1'b0;
                        out_data_next                  = '0;
                        out_data_next.expired_slot     = SLOT_W'(chk_idx_reg);
                        out_data_next.expired_type     = ram_rd_data.kind;
                    end
                    else if (hit && (!found_reg || (ram_rd_data.expiry < earliest_reg)))
                    begin
                        earliest_next = ram_rd_data.expiry;
                        found_next    = 1'b1;
                    end
                end
            end

            ST_STATUS:
            begin
                if (out_free)
                begin
                    out_valid_next                 = 1'b1;
                    out_exp_next                   = 1'b0;
                    out_last_next                  = 1'b1;
                    out_data_next                  = '0;
                    out_data_next.expired_count    = COUNT_W'(count_reg);
                    out_data_next.next_deadline_ms = deadline;
                    out_data_next.none_pending     = !found_reg;
                    state_next                     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            now_reg       <= '0;
            armed_reg     <= '0;
            chk_valid_reg <= 1'b0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            armed_reg     <= armed_next;
            chk_valid_reg <= chk_valid_next;
            rd_cnt_reg    <= rd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        chk_idx_reg  <= chk_idx_next;
        count_reg    <= count_next;
        found_reg    <= found_next;
        earliest_reg <= earliest_next;
        out_data_reg <= out_data_next;
        out_exp_reg  <= out_exp_next;
        out_last_reg <= out_last_next;
    end

endmodule

@@ sv/timer_table_expiry_engine.sv @@
`timescale 1ns / 1ps
// Timer table expiry engine: keeps a millisecond clock and a table of armed timer slots.
// Slave channel s_*: one transaction per command (schedule, cancel, tick, cancel all).
// Master channel m_*: zero or more expiry reports, then one status result with tlast high.
// A tick advances the clock by one millisecond and reports, in ascending slot order,
// every armed slot whose expiry is at or before the new time, disarming it.
// The status result carries the expired count, the time to the earliest armed expiry
// (zero when due, saturated at all ones) and the none-pending flag.
// A command passes a staging register and a two-entry queue; the engine then applies it,
// scans the table through the registered read port of the slot RAM, and emits the status.
// The scan checks one table entry per cycle while no expiry report is held up, and the
// engine takes no new command until it has emitted the status result of the last one.
// Reset clears the clock and all armed bits; table contents need no clearing.
// When m_tready is low the scan halts on the next expiry report and the queue fills,
// after which s_tready drops; no result is lost.
module timer_table_expiry_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tte_pkg::S_TDATA_W-1:0]   s_tdata,  // slot[4:0], wait_ms[36:5], timer_type[40:37], zero pad
    input  logic [tte_pkg::ACT_W-1:0]       s_tuser,  // action[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tte_pkg::M_TDATA_W-1:0]   m_tdata,  // expired_slot[4:0], expired_type[8:5],
                                                      // expired_count[14:9],
                                                      // next_deadline_ms[46:15], none_pending[47]
    output logic                            m_tuser,  // is_expiry
    output logic                            m_tlast
);
    import tte_pkg::*;

    logic    front_valid;
    logic    front_ready;
    cmd_t    front_cmd;
    logic    q_valid;
    logic    q_ready;
    cmd_t    q_cmd;
    m_data_t out_data;

    tte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_data_t'(s_tdata)),
        .s_tuser   (s_tuser),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    tte_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_cmd   (front_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    tte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (out_data),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    assign m_tdata = M_TDATA_W'(out_data);

    // Expiry reports never close an item and carry no count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> !m_tlast && (m_tdata[14:9] == '0))
        else $error("expiry report marked last or carrying a count");

    // Nothing pending means no deadline
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tdata[47] |-> (m_tdata[46:15] == '0))
        else $error("deadline reported with no armed slot");

    // A status count never exceeds the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> (m_tdata[14:9] <= COUNT_W'(NUM_SLOTS)))
        else $error("expired count above table size");

    // Taking a queued command moves the engine out of idle
    assert property (@(posedge clk) disable iff (!rst_n)
        q_ready && q_valid |=> !q_ready)
        else $error("engine did not start on a queued command");

endmodule

@@ tb/timer_table_expiry_engine_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for timer_table_expiry_engine: a directed opening, then random traffic
// of all four actions under varying back-pressure, checked against a local timer model.
// Depends on tte_pkg and the engine RTL.
module timer_table_expiry_engine_tb;

    import tte_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int PHASE_ITEMS    = 60;

    // One command as it travels on the slave side
    typedef struct packed {
        act_t               act;
        logic [SLOT_W-1:0]  slot;
        logic [DELAY_W-1:0] delay;
        logic [KIND_W-1:0]  kind;
    } timer_cmd_t;

    // One result as it travels on the master side
    typedef struct packed {
        logic    is_expiry;
        logic    last;
        m_data_t data;
    } timer_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [ACT_W-1:0]     s_tuser = ACT_SCHEDULE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // Local copy of the timer table
    logic [TIME_W-1:0] now_ms = '0;
    logic [TIME_W-1:0] slot_due [NUM_SLOTS];
    logic [KIND_W-1:0] slot_tag [NUM_SLOTS];
    logic              slot_live [NUM_SLOTS];

    timer_cmd_t    cmd_queue [$];
    timer_result_t expected_results [$];
    timer_cmd_t    on_bus;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            mismatches = 0;
    int            idle_cycles = 0;

    timer_table_expiry_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Apply one accepted command to the local table and queue the results it causes
    task automatic apply_timer_cmd(input timer_cmd_t c);
        timer_result_t     r;
        logic [COUNT_W-1:0] n_expired;
        logic [TIME_W-1:0]  earliest;
        logic [TIME_W-1:0]  gap;
        logic               found;
        n_expired = '0;
        earliest  = '0;
        found     = 1'b0;
        case (c.act)
            ACT_SCHEDULE:
            begin
                if (int'(c.slot) < NUM_SLOTS)
                begin
                    slot_due[c.slot]  = now_ms + TIME_W'(c.delay);
                    slot_tag[c.slot]  = c.kind;
                    slot_live[c.slot] = 1'b1;
                end
            end
            ACT_CANCEL:
            begin
                if (int'(c.slot) < NUM_SLOTS)
                    slot_live[c.slot] = 1'b0;
            end
            ACT_TICK:
            begin
                now_ms = now_ms + 1'b1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_live[i] && slot_due[i] <= now_ms)
                    begin
                        slot_live[i] = 1'b0;
                        r = '0;
                        r.is_expiry = 1'b1;
                        r.data.expired_slot = SLOT_W'(i);
                        r.data.expired_type = slot_tag[i];
                        expected_results.push_back(r);
                        n_expired++;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    slot_live[i] = 1'b0;
            end
        endcase

        // Closing status: time to the earliest armed expiry
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (slot_live[i] && (!found || slot_due[i] < earliest))
            begin
                earliest = slot_due[i];
                found    = 1'b1;
            end
        end
        r = '0;
        r.last = 1'b1;
        r.data.expired_count = n_expired;
        r.data.none_pending  = !found;
        if (found && earliest > now_ms)
        begin
            gap = earliest - now_ms;
            r.data.next_deadline_ms = (gap > TIME_W'(32'hFFFF_FFFF)) ? '1 : gap[DEADLINE_W-1:0];
        end
        expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_cmd(input act_t act, input int slot, input logic [DELAY_W-1:0] delay,
                             input int kind);
        timer_cmd_t c;
        c.act   = act;
        c.slot  = SLOT_W'(slot);
        c.delay = delay;
        c.kind  = KIND_W'(kind);
        cmd_queue.push_back(c);
    endtask

    // Mostly short delays so slots actually expire; some huge ones to reach the saturation edge
    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return DELAY_W'($urandom_range(6));
        else if (r < 85)
            return DELAY_W'($urandom_range(1000));
        else if (r < 93)
            return $urandom;
        else
            return 32'hFFFF_FFFF - DELAY_W'($urandom_range(3));
    endfunction

    task automatic queue_random_traffic(input int n_items);
        int k;
        int pick;
        k = 0;
        while (k < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
            begin
                // fill the whole table with near-due timers, then tick them all out
                for (int s = 0; s < NUM_SLOTS; s++)
                    queue_cmd(ACT_SCHEDULE, s, DELAY_W'($urandom_range(2)), $urandom_range(15));
                repeat (3) queue_cmd(ACT_TICK, $urandom_range(31), $urandom, $urandom_range(15));
                k += NUM_SLOTS + 3;
            end
            else if (pick < 40)
            begin
                queue_cmd(ACT_SCHEDULE, $urandom_range(31), pick_delay(), $urandom_range(15));
                k++;
            end
            else if (pick < 80)
            begin
                queue_cmd(ACT_TICK, $urandom_range(31), $urandom, $urandom_range(15));
                k++;
            end
            else if (pick < 95)
            begin
                queue_cmd(ACT_CANCEL, $urandom_range(31), $urandom, $urandom_range(15));
                k++;
            end
            else
            begin
                queue_cmd(ACT_CANCEL_ALL, $urandom_range(31), $urandom, $urandom_range(15));
                k++;
            end
        end
    endtask

    // Wait until every queued command is sent and every result is back
    task automatic wait_drained();
        while (cmd_queue.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    // Slave-side driver: one transaction per command, random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= ACT_SCHEDULE;
        end
        else
        begin
            if (s_tvalid && s_tready)
                apply_timer_cmd(on_bus);
            if (!s_tvalid || s_tready)
            begin
                if (cmd_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    on_bus = cmd_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'b0, on_bus.kind, on_bus.delay, on_bus.slot};
                    s_tuser  <= on_bus.act;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Master-side monitor: compare each result with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t want;
        m_data_t       got;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: tuser %0b tdata %h", m_tuser, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("is_expiry", want.is_expiry, m_tuser);
                    check_field("last", want.last, m_tlast);
                    check_field("expired_slot", want.data.expired_slot, got.expired_slot);
                    check_field("expired_type", want.data.expired_type, got.expired_type);
                    check_field("expired_count", want.data.expired_count, got.expired_count);
                    check_field("next_deadline_ms", want.data.next_deadline_ms,
                                got.next_deadline_ms);
                    check_field("none_pending", want.data.none_pending, got.none_pending);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            slot_live[i] = 1'b0;
            slot_due[i]  = '0;
            slot_tag[i]  = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, overdue and saturated deadlines, re-arm, cancels
        queue_cmd(ACT_TICK, 0, 32'h0, 0);
        queue_cmd(ACT_SCHEDULE, 0, 32'h0, 0);
        queue_cmd(ACT_SCHEDULE, 31, 32'hFFFF_FFFF, 15);
        queue_cmd(ACT_TICK, 31, 32'hFFFF_FFFF, 15);
        queue_cmd(ACT_CANCEL, 31, 32'h0, 0);
        queue_cmd(ACT_CANCEL, 31, 32'h0, 0);           // already disarmed
        queue_cmd(ACT_SCHEDULE, 5, 32'd3, 10);
        queue_cmd(ACT_SCHEDULE, 5, 32'd1, 6);          // replaces the earlier arming
        queue_cmd(ACT_TICK, 0, 32'h0, 0);
        queue_cmd(ACT_SCHEDULE, 31, 32'hFFFF_FFFF, 15); // deadline exactly all ones
        queue_cmd(ACT_SCHEDULE, 3, 32'h0, 3);
        queue_cmd(ACT_SCHEDULE, 1, 32'h0, 1);
        queue_cmd(ACT_SCHEDULE, 2, 32'h0, 2);
        queue_cmd(ACT_SCHEDULE, 4, 32'd2, 4);
        queue_cmd(ACT_TICK, 0, 32'h0, 0);              // several expiries, ascending order
        queue_cmd(ACT_SCHEDULE, 7, 32'h0, 9);
        queue_cmd(ACT_CANCEL, 7, 32'h0, 0);
        queue_cmd(ACT_TICK, 0, 32'h0, 0);              // slot 4 expires, cancelled slot 7 not
        queue_cmd(ACT_CANCEL_ALL, 0, 32'h0, 0);
        queue_cmd(ACT_TICK, 0, 32'h0, 0);
        queue_cmd(ACT_SCHEDULE, 16, 32'hAAAA_5555, 5);
        queue_cmd(ACT_SCHEDULE, 8, 32'h5555_AAAA, 10);
        queue_cmd(ACT_CANCEL_ALL, 31, 32'hFFFF_FFFF, 15);

        // Random traffic over several back-pressure phases
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1:       begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 71; end
                3:       begin send_idle_pct = 16; recv_stall_pct = 16; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            queue_random_traffic(PHASE_ITEMS);
            wait_drained();
        end

        // Let any stray result show up
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
sv/tte_pkg.sv
sv/tte_ram.sv
sv/tte_front.sv
sv/tte_queue.sv
sv/tte_back.sv
sv/timer_table_expiry_engine.sv
tb/timer_table_expiry_engine_tb.sv
